FILE: src/twao_pkg.sv
// Shared types, constants and tables for the tracking-wheel arc odometry block.
// Used by every module under src; depends on nothing.
package twao_pkg;

   localparam int COUNT_WIDTH   = 32;
   localparam int POS_WIDTH     = 32;
   localparam int CORDIC_STAGES = 16;

   // scaled wheel travel: count delta times unsigned Q0.16
   localparam int DM_W = COUNT_WIDTH + 17;
   // CORDIC datapath width, room for travel plus chord term plus gain growth
   localparam int CX_W = DM_W + 3;
   localparam int CX_HI_W = CX_W - 32;
   localparam int DM_HI_W = DM_W - 32;

   localparam logic [29:0] GAIN_Q30 =
      30'(64'd652032874 + (64'd434688583 >> (2 * CORDIC_STAGES)));
   localparam logic [29:0] INV_TWO_PI_Q16 = 30'd683565276;
   localparam logic [30:0] K_MAX = 31'h4000_0000;

   localparam logic [1:0] CSR_INCHES_PER_COUNT = 2'd0;
   localparam logic [1:0] CSR_MIDDLE_OFFSET    = 2'd1;
   localparam logic [1:0] CSR_RIGHT_OFFSET     = 2'd2;

   typedef struct packed {
      logic                          action;
      logic signed [COUNT_WIDTH-1:0] dcm;
      logic signed [COUNT_WIDTH-1:0] dcr;
      logic signed [15:0]            dth;
      logic [31:0]                   avg;
      logic [15:0]                   heading;
   } cmd_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

FILE: src/twao_front.sv
// Front end: accepts ticks, keeps the count and heading baselines, forms deltas.
// Depends on twao_pkg.
module twao_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic signed [31:0]  req_middle_count,
   input  logic signed [31:0]  req_right_count,
   input  logic [15:0]         req_imu_heading,
   input  logic                req_imu_valid,
   input  logic                q_full,
   output logic                q_push,
   output twao_pkg::cmd_type   q_cmd
);

   logic [twao_pkg::COUNT_WIDTH-1:0] last_mc_ff, last_mc_in;
   logic [twao_pkg::COUNT_WIDTH-1:0] last_rc_ff, last_rc_in;
   logic [15:0]                      last_h_ff, last_h_in;
   logic [twao_pkg::COUNT_WIDTH-1:0] mc, rc;
   logic [15:0]                      h, dth;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   assign mc  = req_middle_count[twao_pkg::COUNT_WIDTH-1:0];
   assign rc  = req_right_count[twao_pkg::COUNT_WIDTH-1:0];
   assign h   = req_imu_valid ? req_imu_heading : 16'd0;
   assign dth = h - last_h_ff;

   always_comb begin
      q_cmd.action  = req_action;
      q_cmd.dcm     = $signed(mc - last_mc_ff);
      q_cmd.dcr     = $signed(rc - last_rc_ff);
      q_cmd.dth     = $signed(dth);
      // average heading in 32-bit angle units: last + dth/2
      q_cmd.avg     = {last_h_ff, 16'd0} + {dth[15], dth, 15'd0};
      q_cmd.heading = h;
      last_mc_in = last_mc_ff;
      last_rc_in = last_rc_ff;
      last_h_in  = last_h_ff;
      if (q_push) begin
         last_mc_in = mc;
         last_rc_in = rc;
         last_h_in  = req_action ? 16'd0 : h;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_mc_ff <= '0;
         last_rc_ff <= '0;
         last_h_ff  <= '0;
      end else begin
         last_mc_ff <= last_mc_in;
         last_rc_ff <= last_rc_in;
         last_h_ff  <= last_h_in;
      end
   end

endmodule

FILE: src/twao_fifo.sv
// Two-entry command queue between front end and back end.
// Depends on twao_pkg.
module twao_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  twao_pkg::cmd_type din,
   input  logic              pop,
   output twao_pkg::cmd_type dout,
   output logic              full,
   output logic              empty
);

   twao_pkg::cmd_type mem [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign dout  = mem[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: src/twao_cordic.sv
// Iterative rotation CORDIC with quadrant fold and rounded gain correction.
// Depends on twao_pkg.
module twao_cordic (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [twao_pkg::CX_W-1:0] x0,
   input  logic signed [twao_pkg::CX_W-1:0] y0,
   input  logic [31:0]                      angle,
   output logic                             done,
   output logic signed [twao_pkg::CX_W-1:0] x_out,
   output logic signed [twao_pkg::CX_W-1:0] y_out
);

   localparam int W = twao_pkg::CX_W;
   localparam logic [2:0] C_IDLE = 3'd0;
   localparam logic [2:0] C_ITER = 3'd1;
   localparam logic [2:0] C_GX   = 3'd2;
   localparam logic [2:0] C_GY   = 3'd3;
   localparam logic [2:0] C_FIN  = 3'd4;

   logic [2:0]           state_ff;
   logic signed [W-1:0]  x_ff, y_ff, xs, ys;
   logic signed [33:0]   z_ff, at;
   logic [4:0]           i_ff;
   logic [61:0]          xlo_ff, ylo_ff;
   logic [twao_pkg::CX_HI_W+29:0] xhi_ff, yhi_ff;
   logic                 xneg_ff, yneg_ff, done_ff;
   logic signed [W-1:0]  xo_ff, yo_ff;
   logic [W-1:0]         ax, ay, rx, ry;
   logic                 fold;
   logic [31:0]          t2;

   assign fold = angle[31] ^ angle[30];
   assign t2   = fold ? {~angle[31], angle[30:0]} : angle;
   assign xs   = x_ff >>> i_ff;
   assign ys   = y_ff >>> i_ff;
   assign at   = $signed({2'b00, twao_pkg::atan_entry(i_ff)});
   assign ax   = x_ff[W-1] ? W'(-x_ff) : W'(x_ff);
   assign ay   = y_ff[W-1] ? W'(-y_ff) : W'(y_ff);
   assign rx   = W'({xhi_ff, 2'b00}) + W'((63'(xlo_ff) + 63'(1 << 29)) >> 30);
   assign ry   = W'({yhi_ff, 2'b00}) + W'((63'(ylo_ff) + 63'(1 << 29)) >> 30);

   assign done  = done_ff;
   assign x_out = xo_ff;
   assign y_out = yo_ff;

   always_ff @(posedge clock) begin
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               x_ff <= fold ? -x0 : x0;
               y_ff <= fold ? -y0 : y0;
               z_ff <= 34'($signed(t2));
               i_ff <= 5'd0;
            end
         end
         C_ITER: begin
            if (!z_ff[33]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + at;
            end
            i_ff <= i_ff + 5'd1;
         end
         C_GX: begin
            xlo_ff  <= ax[31:0] * twao_pkg::GAIN_Q30;
            xhi_ff  <= ax[W-1:32] * twao_pkg::GAIN_Q30;
            xneg_ff <= x_ff[W-1];
         end
         C_GY: begin
            ylo_ff  <= ay[31:0] * twao_pkg::GAIN_Q30;
            yhi_ff  <= ay[W-1:32] * twao_pkg::GAIN_Q30;
            yneg_ff <= y_ff[W-1];
         end
         C_FIN: begin
            xo_ff <= xneg_ff ? -$signed(rx) : $signed(rx);
            yo_ff <= yneg_ff ? -$signed(ry) : $signed(ry);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == C_FIN);
         case (state_ff)
            C_IDLE:  if (start) state_ff <= C_ITER;
            C_ITER:  if (i_ff == 5'(twao_pkg::CORDIC_STAGES - 1)) state_ff <= C_GX;
            C_GX:    state_ff <= C_GY;
            C_GY:    state_ff <= C_FIN;
            C_FIN:   state_ff <= C_IDLE;
            default: state_ff <= C_IDLE;
         endcase
      end
   end

endmodule

FILE: src/twao_back.sv
// Back end: chord, divide, rotation and position update for one command at a time.
// Depends on twao_pkg and twao_cordic.
module twao_back (
   input  logic                clock,
   input  logic                reset,
   input  twao_pkg::cmd_type   cmd,
   input  logic                q_empty,
   output logic                q_pop,
   input  logic [15:0]         inches_per_count,
   input  logic signed [23:0]  middle_wheel_offset,
   input  logic signed [23:0]  right_wheel_offset,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_pos_x,
   output logic signed [31:0]  rsp_pos_y,
   output logic [15:0]         rsp_heading_out
);

   localparam int W  = twao_pkg::CX_W;
   localparam int DW = twao_pkg::DM_W;
   localparam int PW = twao_pkg::POS_WIDTH;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_TRAV   = 4'd1;
   localparam logic [3:0] S_SIN    = 4'd2;
   localparam logic [3:0] S_NUM    = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_MX1    = 4'd5;
   localparam logic [3:0] S_MX2    = 4'd6;
   localparam logic [3:0] S_MY1    = 4'd7;
   localparam logic [3:0] S_MY2    = 4'd8;
   localparam logic [3:0] S_RSTART = 4'd9;
   localparam logic [3:0] S_ROT    = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   logic [3:0]             state_ff;
   twao_pkg::cmd_type      cmd_ff;
   logic signed [DW-1:0]   dm_ff, dr_ff, dm_p, dr_p;
   logic signed [33:0]     s_ff;
   logic [30:0]            k_ff;
   logic [46:0]            num_ff, q_fin;
   logic [45:0]            q_ff;
   logic [15:0]            rem_ff;
   logic [5:0]             cnt_ff;
   logic [62:0]            plo_ff;
   logic [twao_pkg::DM_HI_W+30:0] phi_ff;
   logic signed [W-1:0]    lx_ff, ly_ff, lcur;
   logic signed [PW-1:0]   acc_x_ff, acc_y_ff;
   logic                   rsp_valid_ff;
   logic signed [31:0]     pos_x_ff, pos_y_ff;
   logic [15:0]            head_ff;

   logic                   slot_free, load_out, kzero, ge;
   logic [33:0]            s_abs;
   logic [15:0]            ud;
   logic [62:0]            num_in;
   logic [16:0]            rem_in;
   logic signed [DW-1:0]   dcur;
   logic [DW-1:0]          ua, rmag;
   logic signed [57:0]     off_p;
   logic signed [23:0]     off_sel;
   logic signed [W-1:0]    l_in;
   logic                   c_start, c_done;
   logic signed [W-1:0]    c_x0, c_y0, c_x, c_y;
   logic [31:0]            c_t;
   logic signed [PW-1:0]   nx, ny;

   function automatic logic signed [PW-1:0] sat_add(input logic signed [PW-1:0] a,
                                                     input logic signed [W-1:0] b);
      logic signed [W:0] s;
      logic signed [W:0] hi;
      logic signed [W:0] lo;
      s  = (W+1)'(a) + (W+1)'(b);
      hi = (W+1)'({1'b0, {(PW-1){1'b1}}});
      lo = -hi - (W+1)'(1);
      if (s > hi) begin
         return PW'(hi);
      end else if (s < lo) begin
         return PW'(lo);
      end
      return PW'(s);
   endfunction

   twao_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (c_start),
      .x0    (c_x0),
      .y0    (c_y0),
      .angle (c_t),
      .done  (c_done),
      .x_out (c_x),
      .y_out (c_y)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign load_out  = (state_ff == S_OUT) && slot_free;
   assign q_pop     = (state_ff == S_IDLE) && !q_empty;

   assign dm_p  = cmd_ff.dcm * $signed({1'b0, inches_per_count});
   assign dr_p  = cmd_ff.dcr * $signed({1'b0, inches_per_count});
   assign s_abs = s_ff[33] ? 34'(-s_ff) : 34'(s_ff);
   assign ud    = cmd_ff.dth[15] ? 16'(-cmd_ff.dth) : 16'(cmd_ff.dth);
   assign kzero = (s_ff == '0) || (s_ff[33] != cmd_ff.dth[15]);
   assign num_in = 63'(s_abs[31:0]) * 63'(twao_pkg::INV_TWO_PI_Q16) + 63'({ud, 15'd0});
   assign rem_in = {rem_ff, num_ff[46]};
   assign ge     = rem_in >= {1'b0, ud};
   assign q_fin  = {q_ff, ge};

   // one axis at a time: X in the MX states, Y in the MY states
   assign dcur    = (state_ff == S_MX1 || state_ff == S_MX2) ? dm_ff : dr_ff;
   assign off_sel = (state_ff == S_MX2) ? middle_wheel_offset : right_wheel_offset;
   assign ua      = dcur[DW-1] ? DW'(-dcur) : DW'(dcur);
   assign rmag    = DW'({phi_ff, 2'b00}) + DW'((plo_ff + 63'(1 << 29)) >> 30);
   assign off_p   = off_sel * s_ff;
   assign lcur    = dcur[DW-1] ? -W'($signed(rmag)) : W'($signed(rmag));
   assign l_in    = lcur + W'((off_p + 58'sd536870912) >>> 30);

   assign c_start = (state_ff == S_TRAV && cmd_ff.dth != '0) || (state_ff == S_RSTART);
   assign c_x0    = (state_ff == S_TRAV) ? W'(64'sh8000_0000) : lx_ff;
   assign c_y0    = (state_ff == S_TRAV) ? W'(0) : ly_ff;
   assign c_t     = (state_ff == S_TRAV) ? {cmd_ff.dth[15], cmd_ff.dth, 15'd0}
                                         : 32'd0 - cmd_ff.avg;

   assign nx = cmd_ff.action ? PW'(0) : sat_add(acc_x_ff, lx_ff);
   assign ny = cmd_ff.action ? PW'(0) : sat_add(acc_y_ff, ly_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_heading_out = head_ff;

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) cmd_ff <= cmd;
         end
         S_TRAV: begin
            dm_ff <= dm_p;
            dr_ff <= dr_p;
            lx_ff <= W'(dm_p);
            ly_ff <= W'(dr_p);
         end
         S_SIN: begin
            if (c_done) s_ff <= 34'(c_y);
         end
         S_NUM: begin
            num_ff <= num_in[62:16];
            rem_ff <= '0;
            q_ff   <= '0;
            cnt_ff <= '0;
            k_ff   <= '0;
         end
         S_DIV: begin
            rem_ff <= ge ? 16'(rem_in - {1'b0, ud}) : rem_in[15:0];
            q_ff   <= q_fin[45:0];
            num_ff <= {num_ff[45:0], 1'b0};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd46) begin
               k_ff <= (q_fin > 47'(twao_pkg::K_MAX)) ? twao_pkg::K_MAX : q_fin[30:0];
            end
         end
         S_MX1, S_MY1: begin
            plo_ff <= ua[31:0] * k_ff;
            phi_ff <= ua[DW-1:32] * k_ff;
         end
         S_MX2: lx_ff <= l_in;
         S_MY2: ly_ff <= l_in;
         S_ROT: begin
            if (c_done) begin
               lx_ff <= c_x;
               ly_ff <= c_y;
            end
         end
         default: begin
         end
      endcase
      if (load_out) begin
         pos_x_ff <= 32'(nx);
         pos_y_ff <= 32'(ny);
         head_ff  <= cmd_ff.heading;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_out) begin
            acc_x_ff     <= nx;
            acc_y_ff     <= ny;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) state_ff <= cmd.action ? S_OUT : S_TRAV;
            end
            S_TRAV:   state_ff <= (cmd_ff.dth == '0) ? S_RSTART : S_SIN;
            S_SIN:    if (c_done) state_ff <= S_NUM;
            S_NUM:    state_ff <= kzero ? S_MX1 : S_DIV;
            S_DIV:    if (cnt_ff == 6'd46) state_ff <= S_MX1;
            S_MX1:    state_ff <= S_MX2;
            S_MX2:    state_ff <= S_MY1;
            S_MY1:    state_ff <= S_MY2;
            S_MY2:    state_ff <= S_RSTART;
            S_RSTART: state_ff <= S_ROT;
            S_ROT:    if (c_done) state_ff <= S_OUT;
            S_OUT:    if (slot_free) state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != S_IDLE)
      else $error("command popped but sequencer stayed idle");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MX1) |-> (k_ff <= twao_pkg::K_MAX))
      else $error("chord factor above one");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      c_start |=> !c_done)
      else $error("rotation finished in the cycle after start");
`endif

endmodule

FILE: src/tracking_wheel_arc_odometry.sv
// Top level of the tracking-wheel arc odometry block: config registers and wiring.
// Depends on twao_pkg, twao_front, twao_fifo, twao_back.
//
// Usage:
//   req_* carries one tick (or a zero action) per transfer, taken when req_valid
//   is high and req_stall low. rsp_* returns one result per tick, taken when
//   rsp_valid is high and rsp_stall low. csr_* writes one configuration
//   register (index 0 inches per count, 1 middle offset, 2 right offset);
//   csr_ready is always high and other indexes are ignored.
//   From input transfer to rsp_valid, a tick whose heading changed passes a sine
//   CORDIC, a 47-step quotient loop and a rotation CORDIC; the loop is skipped
//   when the chord factor is zero, the sine CORDIC and the loop are skipped when
//   the heading did not change, and a zero action skips all three. The back-end
//   sequencer handles one tick at a time. A two-entry queue lets the front end
//   take ticks while the back end works; req_stall rises only when that queue is
//   full. A stalled result holds on rsp_* while the next tick is processed up to
//   its final write.
//   Reset (synchronous) clears baselines and position and restores the
//   default configuration.
module tracking_wheel_arc_odometry (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic signed [31:0] req_middle_count,
   input  logic signed [31:0] req_right_count,
   input  logic [15:0]        req_imu_heading,
   input  logic               req_imu_valid,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [15:0]        rsp_heading_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_data
);

   logic [15:0]        ipc_ff;
   logic signed [23:0] moff_ff, roff_ff;
   logic               q_push, q_pop, q_full, q_empty;
   twao_pkg::cmd_type  q_din, q_dout;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ipc_ff  <= 16'd1573;
         moff_ff <= 24'sd360448;
         roff_ff <= 24'sd103219;
      end else if (csr_valid) begin
         case (csr_index)
            twao_pkg::CSR_INCHES_PER_COUNT: ipc_ff  <= csr_data[15:0];
            twao_pkg::CSR_MIDDLE_OFFSET:    moff_ff <= $signed(csr_data);
            twao_pkg::CSR_RIGHT_OFFSET:     roff_ff <= $signed(csr_data);
            default: begin
            end
         endcase
      end
   end

   twao_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_middle_count (req_middle_count),
      .req_right_count  (req_right_count),
      .req_imu_heading  (req_imu_heading),
      .req_imu_valid    (req_imu_valid),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (q_din)
   );

   twao_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .full  (q_full),
      .empty (q_empty)
   );

   twao_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (q_dout),
      .q_empty             (q_empty),
      .q_pop               (q_pop),
      .inches_per_count    (ipc_ff),
      .middle_wheel_offset (moff_ff),
      .right_wheel_offset  (roff_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pos_x           (rsp_pos_x),
      .rsp_pos_y           (rsp_pos_y),
      .rsp_heading_out     (rsp_heading_out)
   );

endmodule
